@@ rtl/score_result_transform_assert.svh @@
// Assertion macros used by the score transform checker.
`ifndef SCORE_RESULT_TRANSFORM_ASSERT_SVH
`define SCORE_RESULT_TRANSFORM_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SRT_CHECK(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("score transform port check failed");

// Next-cycle implication, disabled while reset is high.
`define SRT_CHECK_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("score transform port check failed");

`endif

@@ rtl/srt_pkg.sv @@
// Shared types and constants of the score transform block.
`default_nettype none

package srt_pkg;

   // Table geometry
   localparam int MAX_ENTRIES = 8;
   localparam int ENT_IDX_W   = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = 4;

   // Commands carried in tuser
   localparam logic [1:0] CMD_SCORE  = 2'd0;
   localparam logic [1:0] CMD_STEP   = 2'd1;
   localparam logic [1:0] CMD_INTERP = 2'd2;

   // Register indexes
   localparam logic [2:0] REG_MODE           = 3'd0;
   localparam logic [2:0] REG_CLAMP_MIN      = 3'd1;
   localparam logic [2:0] REG_CLAMP_MAX      = 3'd2;
   localparam logic [2:0] REG_STEP_COUNT     = 3'd3;
   localparam logic [2:0] REG_STEP_DEFAULT   = 3'd4;
   localparam logic [2:0] REG_INTERP_COUNT   = 3'd5;
   localparam logic [2:0] REG_INTERP_DEFAULT = 3'd6;

   // Distribution kinds
   localparam logic [1:0] DIST_NONE = 2'd0;
   localparam logic [1:0] DIST_YUNI = 2'd1;
   localparam logic [1:0] DIST_XUNI = 2'd2;
   localparam logic [1:0] DIST_ZERO = 2'd3;

   // Pipelined divider geometry: one quotient bit per stage
   localparam int DIV_NUM_W = 64;
   localparam int DIV_DEN_W = 33;
   localparam int DIV_Q_W   = 35;
   localparam int DIV_LAT   = DIV_Q_W + 1;

   localparam logic signed [33:0] FRAC_ONE = 34'sd65536;
   localparam logic signed [31:0] SAT_MAX  = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] SAT_MIN  = 32'sh8000_0000;

   // One item as it moves through the front of the pipeline
   typedef struct packed {
      logic [1:0]          cmd;
      logic [2:0]          idx;
      logic signed [31:0]  thr;
      logic signed [31:0]  val;
      logic signed [31:0]  x;
   } item_type;

   // Side band beside the distribution divider
   typedef struct packed {
      item_type   item;
      logic [1:0] kind;
      logic       neg;
      logic       dzero;
   } sb1_type;

   // Side band beside the interpolation divider
   typedef struct packed {
      logic [1:0]          cmd;
      logic signed [31:0]  vl;
      logic                neg;
      logic                byp;
      logic signed [31:0]  byp_val;
   } sb2_type;

endpackage

`default_nettype wire

@@ rtl/srt_divider.sv @@
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
`default_nettype none

module srt_divider (
   input  wire logic                           clock,
   input  wire logic                           adv,
   input  wire logic [srt_pkg::DIV_NUM_W-1:0]  num_in,
   input  wire logic [srt_pkg::DIV_DEN_W-1:0]  den_in,
   output logic      [srt_pkg::DIV_Q_W-1:0]    quo_out,
   output logic                                ovf_out
);

   localparam int NW  = srt_pkg::DIV_NUM_W;
   localparam int DW  = srt_pkg::DIV_DEN_W;
   localparam int QW  = srt_pkg::DIV_Q_W;
   localparam int LAT = srt_pkg::DIV_LAT;

   logic [DW-1:0] rem_ff [LAT];
   logic [QW-1:0] num_ff [LAT];
   logic [QW-1:0] quo_ff [LAT];
   logic [DW-1:0] den_ff [LAT];
   logic          ovf_ff [LAT];

   logic [DW:0]   trial [LAT];
   logic [DW:0]   diff  [LAT];
   logic          take  [LAT];

   // Trial subtraction of every stage
   always_comb begin
      trial[0] = '0;
      diff[0]  = '0;
      take[0]  = 1'b0;
      for (int k = 1; k < LAT; k++) begin
         trial[k] = {rem_ff[k-1], num_ff[k-1][QW-1]};
         diff[k]  = trial[k] - {1'b0, den_ff[k-1]};
         take[k]  = trial[k] >= {1'b0, den_ff[k-1]};
      end
   end

   // Stage registers; the first one checks for a quotient beyond QW bits
   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= DW'(num_in[NW-1:QW]);
         num_ff[0] <= num_in[QW-1:0];
         quo_ff[0] <= '0;
         den_ff[0] <= den_in;
         ovf_ff[0] <= DW'(num_in[NW-1:QW]) >= den_in;
         for (int k = 1; k < LAT; k++) begin
            rem_ff[k] <= take[k] ? diff[k][DW-1:0] : trial[k][DW-1:0];
            num_ff[k] <= {num_ff[k-1][QW-2:0], 1'b0};
            quo_ff[k] <= {quo_ff[k-1][QW-2:0], take[k]};
            den_ff[k] <= den_ff[k-1];
            ovf_ff[k] <= ovf_ff[k-1];
         end
      end
   end

   assign quo_out = quo_ff[LAT-1];
   assign ovf_out = ovf_ff[LAT-1];

endmodule

`default_nettype wire

@@ rtl/score_result_transform.sv @@
// Score transform: clamp, distribution map, step table and interpolation.
// Usage:
//   req_* carries one item per transfer: tuser is the command, tdata the
//   entry index, threshold, value and score. A score command yields one
//   transfer on rsp_*; table write commands yield none and take effect for
//   every later item, in stream order.
//   csr_* is an APB-style register port, pready always high.
// Pipeline: two 36-stage pipelined dividers (distribution map,
//   interpolation) plus nine register stages.
// Throughput: one item per cycle; every stage holds its register when the
//   output register is full and rsp_tready is low.
// Stall: while a result waits with rsp_tready low, req_tready is low and
//   the whole pipeline holds; nothing is lost or repeated.
// Reset: registers take their reset values, all valid bits clear. Table
//   entries hold no value until written by a write command.
`default_nettype none

module score_result_transform (
   input  wire logic          clock,
   input  wire logic          reset,
   // tdata: entry_index[2:0], entry_threshold[34:3], entry_value[66:35],
   //        score[98:67], zero pad[103:99]
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [103:0]  req_tdata,
   // tuser: cmd[1:0]
   input  wire logic [1:0]    req_tuser,
   // tdata: transformed[31:0]
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [31:0]        rsp_tdata,
   input  wire logic          csr_psel,
   input  wire logic          csr_penable,
   input  wire logic          csr_pwrite,
   input  wire logic [4:0]    csr_paddr,
   input  wire logic [31:0]   csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   localparam int LAT = srt_pkg::DIV_LAT;
   localparam int NE  = srt_pkg::MAX_ENTRIES;
   localparam int CW  = srt_pkg::CNT_W;
   localparam int IW  = srt_pkg::ENT_IDX_W;

   function automatic logic [CW-1:0] clip_count(logic [CW-1:0] c);
      clip_count = (c > CW'(NE)) ? CW'(NE) : c;
   endfunction

   // Global advance: pipeline moves when the output register can take data
   logic adv;
   logic rsp_valid_ff;
   logic signed [31:0] rsp_data_ff;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Configuration registers
   logic [4:0]         mode_ff;
   logic signed [31:0] clamp_min_ff;
   logic signed [31:0] clamp_max_ff;
   logic [CW-1:0]      step_count_ff;
   logic signed [31:0] step_default_ff;
   logic [CW-1:0]      interp_count_ff;
   logic signed [31:0] interp_default_ff;
   logic               csr_wr;
   logic [2:0]         csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff           <= '0;
         clamp_min_ff      <= srt_pkg::SAT_MIN;
         clamp_max_ff      <= srt_pkg::SAT_MAX;
         step_count_ff     <= '0;
         step_default_ff   <= '0;
         interp_count_ff   <= '0;
         interp_default_ff <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            srt_pkg::REG_MODE:           mode_ff           <= csr_pwdata[4:0];
            srt_pkg::REG_CLAMP_MIN:      clamp_min_ff      <= csr_pwdata;
            srt_pkg::REG_CLAMP_MAX:      clamp_max_ff      <= csr_pwdata;
            srt_pkg::REG_STEP_COUNT:     step_count_ff     <= csr_pwdata[CW-1:0];
            srt_pkg::REG_STEP_DEFAULT:   step_default_ff   <= csr_pwdata;
            srt_pkg::REG_INTERP_COUNT:   interp_count_ff   <= csr_pwdata[CW-1:0];
            srt_pkg::REG_INTERP_DEFAULT: interp_default_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   // Register readback
   always_comb begin
      case (csr_idx)
         srt_pkg::REG_MODE:           csr_prdata = 32'(mode_ff);
         srt_pkg::REG_CLAMP_MIN:      csr_prdata = clamp_min_ff;
         srt_pkg::REG_CLAMP_MAX:      csr_prdata = clamp_max_ff;
         srt_pkg::REG_STEP_COUNT:     csr_prdata = 32'(step_count_ff);
         srt_pkg::REG_STEP_DEFAULT:   csr_prdata = step_default_ff;
         srt_pkg::REG_INTERP_COUNT:   csr_prdata = 32'(interp_count_ff);
         srt_pkg::REG_INTERP_DEFAULT: csr_prdata = interp_default_ff;
         default:                     csr_prdata = '0;
      endcase
   end

   // Stage 1: input register
   logic              v1_ff;
   srt_pkg::item_type it1_ff;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv) v1_ff <= req_tvalid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         it1_ff <= '{cmd: req_tuser, idx: req_tdata[2:0], thr: req_tdata[34:3],
                     val: req_tdata[66:35], x: req_tdata[98:67]};
      end
   end

   // Stage 2: clamp when mode bit 0 is set, upper bound first so the lower bound wins
   logic              v2_ff;
   srt_pkg::item_type it2_ff;
   logic signed [31:0] xc;

   always_comb begin
      xc = it1_ff.x;
      if (mode_ff[0]) begin
         if (xc > clamp_max_ff) xc = clamp_max_ff;
         if (xc < clamp_min_ff) xc = clamp_min_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (adv) v2_ff <= v1_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         it2_ff <= '{cmd: it1_ff.cmd, idx: it1_ff.idx, thr: it1_ff.thr,
                     val: it1_ff.val, x: xc};
      end
   end

   // Distribution setup: divisor 1 +/- x, magnitudes into the divider
   logic signed [33:0] x34, dd, dd_neg;
   logic [31:0]        ax;
   logic [32:0]        ad;
   srt_pkg::sb1_type   sb1_in;

   always_comb begin
      x34    = $signed({{2{it2_ff.x[31]}}, it2_ff.x});
      dd     = (mode_ff[2:1] == srt_pkg::DIST_YUNI) ? srt_pkg::FRAC_ONE + x34
                                                    : srt_pkg::FRAC_ONE - x34;
      dd_neg = -dd;
      ax     = it2_ff.x[31] ? 32'(-x34) : it2_ff.x;
      ad     = dd[33] ? dd_neg[32:0] : dd[32:0];
      sb1_in.item  = it2_ff;
      sb1_in.kind  = mode_ff[2:1];
      sb1_in.neg   = it2_ff.x[31] ^ dd[33];
      sb1_in.dzero = (dd == '0);
   end

   logic [srt_pkg::DIV_Q_W-1:0] q1;
   logic                        ovf1;

   srt_divider u_div_dist (
      .clock   (clock),
      .adv     (adv),
      .num_in  ({16'd0, ax, 16'd0}),
      .den_in  (ad),
      .quo_out (q1),
      .ovf_out (ovf1)
   );

   // Side band line beside the distribution divider
   srt_pkg::sb1_type sb1_ff [LAT];
   logic             vd1_ff [LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LAT; k++) vd1_ff[k] <= 1'b0;
      end else if (adv) begin
         vd1_ff[0] <= v2_ff;
         for (int k = 1; k < LAT; k++) vd1_ff[k] <= vd1_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sb1_ff[0] <= sb1_in;
         for (int k = 1; k < LAT; k++) sb1_ff[k] <= sb1_ff[k-1];
      end
   end

   // Stage 4: distribution result with saturation
   srt_pkg::sb1_type   sb1_out;
   logic signed [31:0] xd;
   logic               q1_big;
   logic              v4_ff;
   srt_pkg::item_type it4_ff;

   always_comb begin
      sb1_out = sb1_ff[LAT-1];
      q1_big  = ovf1 || (|q1[srt_pkg::DIV_Q_W-1:31]);
      case (sb1_out.kind)
         srt_pkg::DIST_NONE: xd = sb1_out.item.x;
         srt_pkg::DIST_ZERO: xd = '0;
         default: begin
            if (sb1_out.dzero)  xd = '0;
            else if (q1_big)    xd = sb1_out.neg ? srt_pkg::SAT_MIN : srt_pkg::SAT_MAX;
            else if (sb1_out.neg) xd = 32'd0 - q1[31:0];
            else                xd = q1[31:0];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (adv) v4_ff <= vd1_ff[LAT-1];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         it4_ff <= '{cmd: sb1_out.item.cmd, idx: sb1_out.item.idx,
                     thr: sb1_out.item.thr, val: sb1_out.item.val, x: xd};
      end
   end

   // Stage 5: step table lookup and step table writes
   logic signed [31:0] st_thr_ff [NE];
   logic signed [31:0] st_val_ff [NE];
   logic [CW-1:0]      st_n;
   logic signed [31:0] xs;
   logic              v5_ff;
   srt_pkg::item_type it5_ff;

   always_comb begin
      st_n = clip_count(step_count_ff);
      xs   = step_default_ff;
      for (int i = 0; i < NE; i++) begin
         if (CW'(i) < st_n && it4_ff.x > st_thr_ff[i]) xs = st_val_ff[i];
      end
      if (!mode_ff[3]) xs = it4_ff.x;
   end

   always_ff @(posedge clock) begin
      if (adv && v4_ff && it4_ff.cmd == srt_pkg::CMD_STEP &&
          CW'(it4_ff.idx) < CW'(NE)) begin
         st_thr_ff[it4_ff.idx[IW-1:0]] <= it4_ff.thr;
         st_val_ff[it4_ff.idx[IW-1:0]] <= it4_ff.val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else if (adv) v5_ff <= v4_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         it5_ff <= '{cmd: it4_ff.cmd, idx: it4_ff.idx, thr: it4_ff.thr,
                     val: it4_ff.val, x: xs};
      end
   end

   // Stage 6: count interpolation thresholds below x; table writes
   logic signed [31:0] ip_thr_ff [NE];
   logic signed [31:0] ip_val_ff [NE];
   logic [CW-1:0]      ip_n, ip_r;
   logic               v6_ff;
   logic [1:0]         cmd6_ff;
   logic signed [31:0] x6_ff;
   logic [CW-1:0]      r6_ff, n6_ff;

   always_comb begin
      ip_n = clip_count(interp_count_ff);
      ip_r = '0;
      for (int i = 0; i < NE; i++) begin
         if (CW'(i) < ip_n && it5_ff.x > ip_thr_ff[i]) ip_r = ip_r + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && v5_ff && it5_ff.cmd == srt_pkg::CMD_INTERP &&
          CW'(it5_ff.idx) < CW'(NE)) begin
         ip_thr_ff[it5_ff.idx[IW-1:0]] <= it5_ff.thr;
         ip_val_ff[it5_ff.idx[IW-1:0]] <= it5_ff.val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v6_ff <= 1'b0;
      else if (adv) v6_ff <= v5_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cmd6_ff <= it5_ff.cmd;
         x6_ff   <= it5_ff.x;
         r6_ff   <= ip_r;
         n6_ff   <= ip_n;
      end
   end

   // Stage 7: pick the segment ends, or a value that needs no division
   logic [CW-1:0]      rm1, nm1;
   logic               byp;
   logic signed [31:0] byp_val;
   logic               v7_ff;
   logic [1:0]         cmd7_ff;
   logic signed [31:0] x7_ff, tl7_ff, tr7_ff, vl7_ff, vr7_ff, bv7_ff;
   logic               byp7_ff;

   always_comb begin
      rm1 = r6_ff - 1'b1;
      nm1 = n6_ff - 1'b1;
      byp     = 1'b1;
      byp_val = x6_ff;
      if (!mode_ff[4])            byp_val = x6_ff;
      else if (n6_ff == '0)       byp_val = interp_default_ff;
      else if (r6_ff == '0)       byp_val = ip_val_ff[0];
      else if (r6_ff == n6_ff)    byp_val = ip_val_ff[nm1[IW-1:0]];
      else                        byp = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) v7_ff <= 1'b0;
      else if (adv) v7_ff <= v6_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cmd7_ff <= cmd6_ff;
         x7_ff   <= x6_ff;
         tl7_ff  <= ip_thr_ff[rm1[IW-1:0]];
         tr7_ff  <= ip_thr_ff[r6_ff[IW-1:0]];
         vl7_ff  <= ip_val_ff[rm1[IW-1:0]];
         vr7_ff  <= ip_val_ff[r6_ff[IW-1:0]];
         byp7_ff <= byp;
         bv7_ff  <= byp_val;
      end
   end

   // Stage 8: differences, sign and magnitudes
   logic signed [32:0] dt, dv, dx, ndt, ndv, ndx;
   logic               v8_ff;
   logic [31:0]        a8_ff, b8_ff, c8_ff;
   srt_pkg::sb2_type   sb8_ff;

   always_comb begin
      dt  = $signed({tr7_ff[31], tr7_ff}) - $signed({tl7_ff[31], tl7_ff});
      dv  = $signed({vr7_ff[31], vr7_ff}) - $signed({vl7_ff[31], vl7_ff});
      dx  = $signed({x7_ff[31], x7_ff})   - $signed({tl7_ff[31], tl7_ff});
      ndt = -dt;
      ndv = -dv;
      ndx = -dx;
   end

   always_ff @(posedge clock) begin
      if (reset) v8_ff <= 1'b0;
      else if (adv) v8_ff <= v7_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a8_ff          <= dv[32] ? ndv[31:0] : dv[31:0];
         b8_ff          <= dx[32] ? ndx[31:0] : dx[31:0];
         c8_ff          <= dt[32] ? ndt[31:0] : dt[31:0];
         sb8_ff.cmd     <= cmd7_ff;
         sb8_ff.vl      <= vl7_ff;
         sb8_ff.neg     <= dv[32] ^ dx[32] ^ dt[32];
         sb8_ff.byp     <= byp7_ff || (dt == '0);
         sb8_ff.byp_val <= byp7_ff ? bv7_ff : vl7_ff;
      end
   end

   // Stage 9: product of the magnitudes
   logic               v9_ff;
   logic [63:0]        prod9_ff;
   logic [31:0]        c9_ff;
   srt_pkg::sb2_type   sb9_ff;

   always_ff @(posedge clock) begin
      if (reset) v9_ff <= 1'b0;
      else if (adv) v9_ff <= v8_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod9_ff <= a8_ff * b8_ff;
         c9_ff    <= c8_ff;
         sb9_ff   <= sb8_ff;
      end
   end

   logic [srt_pkg::DIV_Q_W-1:0] q2;
   logic                        ovf2;

   srt_divider u_div_interp (
      .clock   (clock),
      .adv     (adv),
      .num_in  (prod9_ff),
      .den_in  ({1'b0, c9_ff}),
      .quo_out (q2),
      .ovf_out (ovf2)
   );

   // Side band line beside the interpolation divider
   srt_pkg::sb2_type sb2_ff [LAT];
   logic             vd2_ff [LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LAT; k++) vd2_ff[k] <= 1'b0;
      end else if (adv) begin
         vd2_ff[0] <= v9_ff;
         for (int k = 1; k < LAT; k++) vd2_ff[k] <= vd2_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sb2_ff[0] <= sb9_ff;
         for (int k = 1; k < LAT; k++) sb2_ff[k] <= sb2_ff[k-1];
      end
   end

   // Final stage: vl +/- quotient, saturated, into the output register
   srt_pkg::sb2_type   sb2_out;
   logic signed [37:0] vle, qe, sum;
   logic signed [31:0] res;
   logic               rsp_valid_in;

   always_comb begin
      sb2_out = sb2_ff[LAT-1];
      vle     = $signed({{6{sb2_out.vl[31]}}, sb2_out.vl});
      qe      = $signed({2'b00, ovf2, q2});
      sum     = sb2_out.neg ? vle - qe : vle + qe;
      if (sb2_out.byp)                 res = sb2_out.byp_val;
      else if (sum > 38'sd2147483647)  res = srt_pkg::SAT_MAX;
      else if (sum < -38'sd2147483648) res = srt_pkg::SAT_MIN;
      else                             res = sum[31:0];
      rsp_valid_in = vd2_ff[LAT-1] && (sb2_out.cmd == srt_pkg::CMD_SCORE);
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (adv) rsp_data_ff <= res;
   end

endmodule

`default_nettype wire

@@ rtl/srt_checker.sv @@
// Port-level checker of the score transform block, with its bind.
`default_nettype none
`include "score_result_transform_assert.svh"

module srt_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic        csr_pready
);

   // A stalled result stays offered with the same data
   `SRT_CHECK_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `SRT_CHECK_NEXT(a_rsp_data, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))

   // A stalled receiver stops request transfers
   `SRT_CHECK(a_req_stall, rsp_tvalid && !rsp_tready, !req_tready)

   // Register port never waits
   `SRT_CHECK(a_pready, 1'b1, csr_pready)

endmodule

bind score_result_transform srt_checker u_srt_checker (.*);

`default_nettype wire
